[design/sobel_gradient_stream_top_macros.svh]
// Assertion helpers for the Sobel gradient stream block.
// Each macro expects clk_i and rst_ni in scope.
`ifndef SOBEL_GRADIENT_STREAM_TOP_MACROS_SVH
`define SOBEL_GRADIENT_STREAM_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SGS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sgs check failed");

// Next-cycle implication, disabled during reset
`define SGS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sgs check failed");

`endif

[design/sgs_pkg.sv]
`timescale 1ns / 1ps
package sgs_pkg;

  // Sizes and field widths
  localparam int unsigned DEF_MAX_WIDTH = 4096;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned PIXEL_W       = 8;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned HGT_W         = 13;
  localparam int unsigned ROW_W         = 12;
  localparam int unsigned GRAD_W        = 11;
  localparam int unsigned MAG_W         = 11;
  localparam int unsigned RAD_W         = 2 * MAG_W;
  localparam int unsigned FIFO_DEPTH    = 4;

  // Register reset values and size limits
  localparam int unsigned MIN_SIZE     = 3;
  localparam int unsigned RESET_WIDTH  = 640;
  localparam int unsigned RESET_HEIGHT = 480;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Gradient pair handed from the window stage to the magnitude unit
  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     frame_last;
  } grad_t;

endpackage

[design/sgs_ram.sv]
`timescale 1ns / 1ps
module sgs_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/sgs_front.sv]
`timescale 1ns / 1ps
module sgs_front #(
  parameter int unsigned MAX_WIDTH = sgs_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sgs_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sgs_pkg::PIXEL_W-1:0]    pixel_i,
  output logic                           push_valid_o,
  output sgs_pkg::grad_t                 push_data_o,
  input  logic                           full_i
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW    = sgs_pkg::PIXEL_W;
  localparam int unsigned RST_WIDTH =
    (sgs_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : sgs_pkg::RESET_WIDTH;

  logic [WID_W-1:0]          width_q;
  logic [sgs_pkg::HGT_W-1:0] height_q;
  logic [COL_W-1:0]          col_q;
  logic [sgs_pkg::ROW_W-1:0] row_q;

  logic                      s1_valid_q;
  logic [PW-1:0]             s1_px_q;
  logic [COL_W-1:0]          s1_col_q;
  logic                      s1_emit_q;
  logic                      s1_last_q;

  logic [PW-1:0]             win_q [3][3];
  logic [PW-1:0]             win_d [3][3];

  logic [WID_W-1:0]          width_clamp;
  logic [sgs_pkg::HGT_W-1:0] height_clamp;
  logic [WID_W-1:0]          col_ext, w_last, col_inc;
  logic [sgs_pkg::HGT_W-1:0] row_ext, h_last, row_inc;
  logic                      border, emit, last, wrap_col, wrap_row;
  logic                      accept, s1_done;
  logic [PW-1:0]             px_z, above, above2;
  logic [PW+1:0]             right_sum, left_sum, bot_sum, top_sum;

  // Clamp a written size into the supported range
  always_comb begin
    int unsigned v;
    v = int'(cfg_data_i);
    if (v < sgs_pkg::MIN_SIZE) begin
      width_clamp  = WID_W'(sgs_pkg::MIN_SIZE);
      height_clamp = sgs_pkg::HGT_W'(sgs_pkg::MIN_SIZE);
    end else begin
      width_clamp  = (v > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : WID_W'(v);
      height_clamp = (v > sgs_pkg::MAX_HEIGHT) ? sgs_pkg::HGT_W'(sgs_pkg::MAX_HEIGHT)
                                               : sgs_pkg::HGT_W'(v);
    end
  end

  // Hold the frame size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WID_W'(RST_WIDTH);
      height_q <= sgs_pkg::HGT_W'(sgs_pkg::RESET_HEIGHT);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sgs_pkg::REG_IMAGE_WIDTH:  width_q  <= width_clamp;
        sgs_pkg::REG_IMAGE_HEIGHT: height_q <= height_clamp;
        default: ;
      endcase
    end
  end

  // Classify the incoming word by its raster position
  always_comb begin
    col_ext  = WID_W'(col_q);
    row_ext  = sgs_pkg::HGT_W'(row_q);
    w_last   = width_q - WID_W'(1);
    h_last   = height_q - sgs_pkg::HGT_W'(1);
    border   = (row_q == '0) || (row_ext >= h_last) || (col_q == '0) || (col_ext >= w_last);
    emit     = (row_ext >= sgs_pkg::HGT_W'(2)) && (row_ext <= h_last) &&
               (col_ext >= WID_W'(2)) && (col_ext <= w_last);
    last     = (row_ext == h_last) && (col_ext == w_last);
    col_inc  = col_ext + WID_W'(1);
    row_inc  = row_ext + sgs_pkg::HGT_W'(1);
    wrap_col = (col_inc >= width_q);
    wrap_row = (row_inc >= height_q);
    px_z     = border ? '0 : pixel_i;
  end

  assign s1_done    = s1_valid_q && !(s1_emit_q && full_i);
  assign in_stall_o = s1_valid_q && !s1_done;
  assign accept     = in_valid_i && !in_stall_o;

  // Advance the position counters and load the window stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_px_q    <= '0;
      s1_col_q   <= '0;
      s1_emit_q  <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_px_q    <= px_z;
        s1_col_q   <= col_q;
        s1_emit_q  <= emit;
        s1_last_q  <= last;
        if (wrap_col) begin
          col_q <= '0;
          row_q <= wrap_row ? '0 : sgs_pkg::ROW_W'(row_inc);
        end else begin
          col_q <= COL_W'(col_inc);
        end
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Row above
  sgs_ram #(
    .DATA_W (PW),
    .DEPTH  (MAX_WIDTH)
  ) u_line_a (
    .clk_i   (clk_i),
    .we_i    (s1_done),
    .waddr_i (s1_col_q),
    .wdata_i (s1_px_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (above)
  );

  // Two rows above
  sgs_ram #(
    .DATA_W (PW),
    .DEPTH  (MAX_WIDTH)
  ) u_line_b (
    .clk_i   (clk_i),
    .we_i    (s1_done),
    .waddr_i (s1_col_q),
    .wdata_i (above),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (above2)
  );

  // Shift the window left and bring in the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = above2;
    win_d[1][2] = above;
    win_d[2][2] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (s1_done) begin
      win_q <= win_d;
    end
  end

  // Weighted column and row sums (1, 2, 1)
  assign right_sum = {2'b00, win_d[0][2]} + {1'b0, win_d[1][2], 1'b0} + {2'b00, win_d[2][2]};
  assign left_sum  = {2'b00, win_d[0][0]} + {1'b0, win_d[1][0], 1'b0} + {2'b00, win_d[2][0]};
  assign bot_sum   = {2'b00, win_d[2][0]} + {1'b0, win_d[2][1], 1'b0} + {2'b00, win_d[2][2]};
  assign top_sum   = {2'b00, win_d[0][0]} + {1'b0, win_d[0][1], 1'b0} + {2'b00, win_d[0][2]};

  // Push the gradient pair of an interior pixel
  assign push_valid_o           = s1_done && s1_emit_q;
  assign push_data_o.grad_x     = sgs_pkg::GRAD_W'($signed({1'b0, right_sum}) -
                                                   $signed({1'b0, left_sum}));
  assign push_data_o.grad_y     = sgs_pkg::GRAD_W'($signed({1'b0, bot_sum}) -
                                                   $signed({1'b0, top_sum}));
  assign push_data_o.frame_last = s1_last_q;

endmodule

[design/sgs_fifo.sv]
`timescale 1ns / 1ps
module sgs_fifo #(
  parameter int unsigned DEPTH = sgs_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sgs_pkg::grad_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sgs_pkg::grad_t data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sgs_pkg::grad_t mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;
  logic           do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

[design/sgs_back.sv]
`timescale 1ns / 1ps
module sgs_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               empty_i,
  output logic                               pop_o,
  input  sgs_pkg::grad_t                     data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [sgs_pkg::GRAD_W-1:0]  grad_x_o,
  output logic signed [sgs_pkg::GRAD_W-1:0]  grad_y_o,
  output logic [sgs_pkg::MAG_W-1:0]          magnitude_o,
  output logic                               frame_last_o
);

  localparam int unsigned MW     = sgs_pkg::MAG_W;
  localparam int unsigned RW     = sgs_pkg::RAD_W;
  localparam int unsigned GW     = sgs_pkg::GRAD_W;
  localparam int unsigned REM_W  = MW + 3;
  localparam int unsigned STEP_W = $clog2(MW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DONE
  } state_e;

  state_e                   state_q;
  logic signed [GW-1:0]     gx_q, gy_q;
  logic                     last_q;
  logic [RW-1:0]            sqx_q, sqy_q, rad_q;
  logic [REM_W-1:0]         rem_q;
  logic [MW-1:0]            root_q;
  logic [STEP_W-1:0]        step_q;
  logic                     out_valid_q;
  logic signed [GW-1:0]     out_gx_q, out_gy_q;
  logic [MW-1:0]            out_mag_q;
  logic                     out_last_q;

  logic signed [2*GW-1:0]   gx_wide, gy_wide;
  logic [RW-1:0]            sqx_d, sqy_d;
  logic [REM_W-1:0]         rem_sh, trial;
  logic                     fits;

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  // Square both gradients
  always_comb begin
    gx_wide = (2*GW)'(gx_q);
    gy_wide = (2*GW)'(gy_q);
    sqx_d   = RW'(gx_wide * gx_wide);
    sqy_d   = RW'(gy_wide * gy_wide);
  end

  // One digit of the square root: bring down two bits, try the next root bit
  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[RW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    fits   = (rem_sh >= trial);
  end

  // Sequence pop, square, sum and root steps; hold the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gx_q        <= '0;
      gy_q        <= '0;
      last_q      <= 1'b0;
      sqx_q       <= '0;
      sqy_q       <= '0;
      rad_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_gx_q    <= '0;
      out_gy_q    <= '0;
      out_mag_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // Drop the taken word unless the next one loads in its place
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            gx_q    <= data_i.grad_x;
            gy_q    <= data_i.grad_y;
            last_q  <= data_i.frame_last;
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          sqx_q   <= sqx_d;
          sqy_q   <= sqy_d;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          rad_q   <= sqx_q + sqy_q;
          rem_q   <= '0;
          root_q  <= '0;
          step_q  <= '0;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          rad_q  <= {rad_q[RW-3:0], 2'b00};
          rem_q  <= fits ? (rem_sh - trial) : rem_sh;
          root_q <= {root_q[MW-2:0], fits};
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(MW - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_gx_q    <= gx_q;
            out_gy_q    <= gy_q;
            out_mag_q   <= root_q;
            out_last_q  <= last_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign grad_x_o     = out_gx_q;
  assign grad_y_o     = out_gy_q;
  assign magnitude_o  = out_mag_q;
  assign frame_last_o = out_last_q;

endmodule

[design/sobel_gradient_stream_top.sv]
`timescale 1ns / 1ps
// 3x3 Sobel gradient stream. Gray pixels enter in raster order on the input
// channel; pixels on the frame border count as zero, and every interior pixel
// gives one word with its horizontal and vertical gradient, the floor square
// root of their summed squares, and a flag on the frame's last word. The word
// for pixel (r,c) becomes available after pixel (r+1,c+1) is taken. Border
// pixels are taken at one per clock while the gradient queue has room. The
// magnitude unit steps through pop, square, sum, 11 root digits and output
// load, and pops no new word before loading its output; a 4-entry queue
// ahead of it absorbs short bursts. Frame width and height are written
// through the configuration port; the user must write them only while the
// block is idle, which the block does not enforce. Writes take effect at once;
// sizes out of range are clamped to 3..MAX_WIDTH and 3..4096. The line stores need no clearing after reset.
`include "sobel_gradient_stream_top_macros.svh"
module sobel_gradient_stream_top #(
  parameter int unsigned MAX_WIDTH = sgs_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sgs_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sgs_pkg::PIXEL_W-1:0]       pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [sgs_pkg::GRAD_W-1:0] grad_x_o,
  output logic signed [sgs_pkg::GRAD_W-1:0] grad_y_o,
  output logic [sgs_pkg::MAG_W-1:0]         magnitude_o,
  output logic                              frame_last_o
);

  logic           push_valid, fifo_full, fifo_empty, pop;
  sgs_pkg::grad_t push_data, pop_data;
  logic [31:0]    sum_sq_chk, mag_lo_chk, mag_hi_chk;

  // Position tracking, line stores and window
  sgs_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_i      (pixel_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .full_i       (fifo_full)
  );

  // Gradient queue
  sgs_fifo #(
    .DEPTH (sgs_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_valid),
    .data_i  (push_data),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .data_o  (pop_data)
  );

  // Magnitude unit and output register
  sgs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (fifo_empty),
    .pop_o        (pop),
    .data_i       (pop_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .grad_x_o     (grad_x_o),
    .grad_y_o     (grad_y_o),
    .magnitude_o  (magnitude_o),
    .frame_last_o (frame_last_o)
  );

  // Bounds of the root for the magnitude check
  assign sum_sq_chk = 32'($signed(grad_x_o) * $signed(grad_x_o)) +
                      32'($signed(grad_y_o) * $signed(grad_y_o));
  assign mag_lo_chk = 32'(magnitude_o) * 32'(magnitude_o);
  assign mag_hi_chk = (32'(magnitude_o) + 32'd1) * (32'(magnitude_o) + 32'd1);

  `SGS_ASSERT_IMP(a_no_push_full, push_valid, !fifo_full)
  `SGS_ASSERT_IMP(a_no_pop_empty, pop, !fifo_empty)
  `SGS_ASSERT_NEXT(a_push_fills, push_valid, !fifo_empty)
  `SGS_ASSERT_IMP(a_mag_floor, out_valid_o, (mag_lo_chk <= sum_sq_chk) && (mag_hi_chk > sum_sq_chk))

endmodule
